// File: sv/grm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the 3x3 ridge marker.
// No dependencies; imported by every module of the block.
package grm_pkg;

    // frame limits
    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 256;
    localparam int MAX_DIM  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;

    // field and counter widths
    localparam int CFG_W  = 9;
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int PR_W   = $clog2(MAX_ROWS + 2);
    localparam int GRAD_W = 16;
    localparam int MAG_W  = 32;
    localparam int OUT_W  = 8;

    // queue between front and back
    localparam int QD      = 8;
    localparam int QPTR_W  = $clog2(QD);
    localparam int QCNT_W  = $clog2(QD + 1);

    // register port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;
    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(200);

    // effective frame size after clamping
    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
    } t_dims;

    // one classified transaction travelling from front to back
    typedef struct packed {
        logic [MAG_W-1:0] mag;      // squared magnitude of the incoming pixel
        logic [COL_W-1:0] pc;       // column of the incoming position
        logic             emit;     // this transaction judges a pixel
        logic             last;     // judged pixel is the last of the frame
        logic [ROW_W-1:0] qr;       // judged pixel row
        logic [COL_W-1:0] qc;       // judged pixel column
        logic             top_ok;
        logic             bot_ok;
        logic             left_ok;
        logic             right_ok;
    } t_item;

    function automatic logic [MAG_W-1:0] max2(input logic [MAG_W-1:0] a,
                                              input logic [MAG_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

// File: sv/grm_front.sv
`timescale 1ns / 1ps
// Front end: accepts input transactions, tracks the frame position,
// classifies each transaction and forms the squared gradient magnitude.
// Depends on grm_pkg.
module grm_front import grm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dims                    i_dims,
    input  logic                     i_restart,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_mode,
    input  logic signed [GRAD_W-1:0] i_grad_x,
    input  logic signed [GRAD_W-1:0] i_grad_y,
    input  logic signed [GRAD_W-1:0] i_grad_z,
    input  logic [QCNT_W-1:0]        i_q_count,
    output logic                     o_push,
    output t_item                    o_item
);

    function automatic logic [GRAD_W-1:0] abs_grad(input logic signed [GRAD_W-1:0] v);
        return v[GRAD_W-1] ? GRAD_W'(~v + 1'b1) : GRAD_W'(v);
    endfunction

    // position of the incoming item and of the judged pixel
    logic [PR_W-1:0]  r_pr, n_pr;
    logic [COL_W-1:0] r_pc, n_pc;
    logic [ROW_W-1:0] r_qr, n_qr;
    logic [COL_W-1:0] r_qc, n_qc;

    // pipeline stages
    logic                r_f1_v, r_f2_v;
    t_item               r_f1_item, r_f2_item;
    logic [GRAD_W-1:0]   r_ax, r_ay, r_az;
    logic [MAG_W-1:0]    r_sqx, r_sqy, r_sqz;

    logic [QCNT_W:0]  used;
    logic             accept, past_end, ignore, adv, emit, q_last, pix_ok;
    logic [ROW_W-1:0] rows_m1;
    logic [COL_W-1:0] cols_m1;
    t_item            cls;

    // queue slots plus items still in the front stages
    assign used = (QCNT_W+1)'(i_q_count) + (QCNT_W+1)'(r_f1_v) + (QCNT_W+1)'(r_f2_v);
    assign o_in_stall = (used >= (QCNT_W+1)'(QD));
    assign accept = i_in_valid && !o_in_stall;

    // classification
    always_comb begin
        rows_m1  = ROW_W'(i_dims.rows - 1'b1);
        cols_m1  = COL_W'(i_dims.cols - 1'b1);
        past_end = (r_pr >= PR_W'(i_dims.rows));
        ignore   = i_mode && !past_end;
        adv      = accept && !ignore;
        pix_ok   = !i_mode && !past_end;
        emit     = !((r_pr == '0) || ((r_pr == PR_W'(1)) && (r_pc == '0)));
        q_last   = emit && (r_qr == rows_m1) && (r_qc == cols_m1);

        cls          = '0;
        cls.pc       = r_pc;
        cls.emit     = emit;
        cls.last     = q_last;
        cls.qr       = r_qr;
        cls.qc       = r_qc;
        cls.top_ok   = (r_qr != '0);
        cls.bot_ok   = (r_qr != rows_m1);
        cls.left_ok  = (r_qc != '0);
        cls.right_ok = (r_qc != cols_m1);
    end

    // next position
    always_comb begin
        n_pr = r_pr;
        n_pc = r_pc;
        n_qr = r_qr;
        n_qc = r_qc;
        if (q_last) begin
            n_pr = '0;
            n_pc = '0;
            n_qr = '0;
            n_qc = '0;
        end else begin
            if (r_pc == cols_m1) begin
                n_pc = '0;
                n_pr = r_pr + 1'b1;
            end else begin
                n_pc = r_pc + 1'b1;
            end
            if (emit) begin
                if (r_qc == cols_m1) begin
                    n_qc = '0;
                    n_qr = r_qr + 1'b1;
                end else begin
                    n_qc = r_qc + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_pr <= '0;
            r_pc <= '0;
            r_qr <= '0;
            r_qc <= '0;
        end else if (adv) begin
            r_pr <= n_pr;
            r_pc <= n_pc;
            r_qr <= n_qr;
            r_qc <= n_qc;
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else begin
            r_f1_v <= adv;
            r_f2_v <= r_f1_v;
        end
    end

    // magnitude datapath: abs, squares, sum
    always_ff @(posedge i_clk) begin
        r_f1_item <= cls;
        r_ax      <= pix_ok ? abs_grad(i_grad_x) : '0;
        r_ay      <= pix_ok ? abs_grad(i_grad_y) : '0;
        r_az      <= pix_ok ? abs_grad(i_grad_z) : '0;
        r_f2_item <= r_f1_item;
        r_sqx     <= MAG_W'(r_ax) * MAG_W'(r_ax);
        r_sqy     <= MAG_W'(r_ay) * MAG_W'(r_ay);
        r_sqz     <= MAG_W'(r_az) * MAG_W'(r_az);
    end

    always_comb begin
        o_item     = r_f2_item;
        o_item.mag = r_sqx + r_sqy + r_sqz;
    end
    assign o_push = r_f2_v;

endmodule

// File: sv/grm_queue.sv
`timescale 1ns / 1ps
// Short FIFO that decouples the classifying front from the window back end.
// Depends on grm_pkg.
module grm_queue import grm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_item             i_item,
    input  logic              i_pop,
    output t_item             o_head,
    output logic              o_head_valid,
    output logic [QCNT_W-1:0] o_count
);

    t_item             r_mem [QD];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QD - 1)) ? '0 : p + 1'b1;
    endfunction

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= ptr_inc(r_wr);
            if (i_pop)  r_rd <= ptr_inc(r_rd);
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

    assign o_head       = r_mem[r_rd];
    assign o_head_valid = (r_count != '0);
    assign o_count      = r_count;

endmodule

// File: sv/grm_back.sv
`timescale 1ns / 1ps
// Back end: two line stores, the 3x3 window, largest and second largest
// neighbor search and the output register. Depends on grm_pkg.
module grm_back import grm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_item            i_head,
    input  logic             i_head_valid,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [OUT_W-1:0] o_row,
    output logic [OUT_W-1:0] o_col,
    output logic             o_is_ridge,
    output logic             o_last
);

    // line stores: one row and two rows back
    logic [MAG_W-1:0] r_lb1 [MAX_COLS];
    logic [MAG_W-1:0] r_lb2 [MAX_COLS];
    logic [MAG_W-1:0] r_mem1, r_mem2;
    logic             r_fwd;
    logic [MAG_W-1:0] r_fw1, r_fw2;

    // stage registers
    logic             r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_out_v;
    t_item            r_s1, r_s2, r_s3, r_s4;
    logic [MAG_W-1:0] r_win [3][3];
    logic [MAG_W-1:0] r_s3_nb [8];
    logic [MAG_W-1:0] r_s3_own, r_s3_m1, r_s4_own, r_s4_m2;
    logic [OUT_W-1:0] r_row, r_col;
    logic             r_ridge, r_last;

    logic out_free, s4_free, s3_free, s2_free, s1_free, s1_go;
    logic [MAG_W-1:0] s1_rd1, s1_rd2;
    logic [MAG_W-1:0] nbv [3][3];
    logic [MAG_W-1:0] nb [8];
    logic [MAG_W-1:0] l1 [4];
    logic [MAG_W-1:0] l2 [2];
    logic [MAG_W-1:0] m1;
    logic [MAG_W-1:0] cand [8];
    logic [MAG_W-1:0] c1 [4];
    logic [MAG_W-1:0] c2 [2];
    logic [MAG_W-1:0] m2;

    // stage flow control
    assign out_free = !r_out_v || !i_out_stall;
    assign s4_free  = !r_s4_v || out_free;
    assign s3_free  = !r_s3_v || s4_free;
    assign s2_free  = !r_s2_v || s3_free;
    assign s1_go    = r_s1_v && s2_free;
    assign s1_free  = !r_s1_v || s2_free;
    assign o_pop    = i_head_valid && s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            if (s1_free)  r_s1_v  <= i_head_valid;
            if (s2_free)  r_s2_v  <= r_s1_v && r_s1.emit;
            if (s3_free)  r_s3_v  <= r_s2_v;
            if (s4_free)  r_s4_v  <= r_s3_v;
            if (out_free) r_out_v <= r_s4_v;
            // same column written in the cycle it is read: take the new data
            if (o_pop)    r_fwd   <= s1_go && (r_s1.pc == i_head.pc);
        end
    end

    // line store read at pop, write as the item leaves stage 1
    assign s1_rd1 = r_fwd ? r_fw1 : r_mem1;
    assign s1_rd2 = r_fwd ? r_fw2 : r_mem2;

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_lb1[r_s1.pc] <= r_s1.mag;
            r_lb2[r_s1.pc] <= s1_rd1;
        end
        if (o_pop) begin
            r_mem1 <= r_lb1[i_head.pc];
            r_mem2 <= r_lb2[i_head.pc];
            r_fw1  <= r_s1.mag;
            r_fw2  <= s1_rd1;
            r_s1   <= i_head;
        end
    end

    // window shift: right column takes the new column
    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= s1_rd2;
            r_win[1][2] <= s1_rd1;
            r_win[2][2] <= r_s1.mag;
            r_s2        <= r_s1;
        end
    end

    // stage 2: zero neighbors outside the frame, find the largest
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                nbv[r][c] = r_win[r][c];
                if ((r == 0 && !r_s2.top_ok) || (r == 2 && !r_s2.bot_ok) ||
                    (c == 0 && !r_s2.left_ok) || (c == 2 && !r_s2.right_ok)) begin
                    nbv[r][c] = '0;
                end
            end
        end
        nb[0] = nbv[0][0];
        nb[1] = nbv[0][1];
        nb[2] = nbv[0][2];
        nb[3] = nbv[1][0];
        nb[4] = nbv[1][2];
        nb[5] = nbv[2][0];
        nb[6] = nbv[2][1];
        nb[7] = nbv[2][2];
        for (int i = 0; i < 4; i++) l1[i] = max2(nb[2*i], nb[2*i+1]);
        for (int i = 0; i < 2; i++) l2[i] = max2(l1[2*i], l1[2*i+1]);
        m1 = max2(l2[0], l2[1]);
    end

    always_ff @(posedge i_clk) begin
        if (s3_free) begin
            r_s3      <= r_s2;
            r_s3_nb   <= nb;
            r_s3_own  <= r_win[1][1];
            r_s3_m1   <= m1;
        end
    end

    // stage 3: largest neighbor strictly below the maximum
    always_comb begin
        for (int k = 0; k < 8; k++) cand[k] = (r_s3_nb[k] < r_s3_m1) ? r_s3_nb[k] : '0;
        for (int i = 0; i < 4; i++) c1[i] = max2(cand[2*i], cand[2*i+1]);
        for (int i = 0; i < 2; i++) c2[i] = max2(c1[2*i], c1[2*i+1]);
        m2 = max2(c2[0], c2[1]);
    end

    always_ff @(posedge i_clk) begin
        if (s4_free) begin
            r_s4     <= r_s3;
            r_s4_own <= r_s3_own;
            r_s4_m2  <= m2;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_row   <= OUT_W'(r_s4.qr);
            r_col   <= OUT_W'(r_s4.qc);
            r_ridge <= (r_s4_own >= r_s4_m2);
            r_last  <= r_s4.last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_row       = r_row;
    assign o_col       = r_col;
    assign o_is_ridge  = r_ridge;
    assign o_last      = r_last;

endmodule

// File: sv/gradient_ridge_mark_3x3_top.sv
`timescale 1ns / 1ps
// Ridge marker over a 3x3 window of squared gradient magnitudes.
// A result travels with the item that causes it (col_count + 1 items after its pixel)
// through 2 front stages, the queue and 5 back stages. Throughput, unless stalled:
// one transaction per cycle, one read and one write per line store each cycle.
// Reset: positions, pipeline and queue cleared, row_count and col_count = 200;
// line store contents are not cleared and may be read before being written.
module gradient_ridge_mark_3x3_top import grm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // register port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_mode,
    input  logic signed [GRAD_W-1:0] i_grad_x,
    input  logic signed [GRAD_W-1:0] i_grad_y,
    input  logic signed [GRAD_W-1:0] i_grad_z,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [OUT_W-1:0]         o_row,
    output logic [OUT_W-1:0]         o_col,
    output logic                     o_is_ridge,
    output logic                     o_last
);

    logic [CFG_W-1:0]  r_row_count, r_col_count;
    logic              cfg_wr;
    t_dims             dims;
    logic              push, pop, head_valid;
    t_item             push_item, head;
    logic [QCNT_W-1:0] q_count;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int hi);
        if (v == '0)       return DIM_W'(1);
        if (int'(v) > hi)  return DIM_W'(hi);
        return DIM_W'(v);
    endfunction

    // register writes
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= DIM_RESET;
            r_col_count <= DIM_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_ROW_COUNT: r_row_count <= pwdata[CFG_W-1:0];
                REG_COL_COUNT: r_col_count <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (paddr[2])
            REG_ROW_COUNT: prdata = DATA_W'(r_row_count);
            REG_COL_COUNT: prdata = DATA_W'(r_col_count);
        endcase
    end

    assign dims.rows = clamp_dim(r_row_count, MAX_ROWS);
    assign dims.cols = clamp_dim(r_col_count, MAX_COLS);

    grm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dims     (dims),
        .i_restart  (cfg_wr),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_mode     (i_mode),
        .i_grad_x   (i_grad_x),
        .i_grad_y   (i_grad_y),
        .i_grad_z   (i_grad_z),
        .i_q_count  (q_count),
        .o_push     (push),
        .o_item     (push_item)
    );

    grm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (push_item),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_count      (q_count)
    );

    grm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_row        (o_row),
        .o_col        (o_col),
        .o_is_ridge   (o_is_ridge),
        .o_last       (o_last)
    );

    // queue never overflows: credit check covers items still in the front stages
    a_q_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (q_count < QCNT_W'(QD)))
        else $error("queue push while full");

    // an accepted transaction always finds a free queue slot
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> (q_count < QCNT_W'(QD)))
        else $error("input accepted without queue credit");

    // a pop only happens with an entry present
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (q_count != '0) && !$isunknown(head.emit))
        else $error("pop from empty queue");

endmodule
